// File: sv/sjtw_pkg.sv
// ----------------------------------------------------------------------------
// sjtw_pkg
// Shared types, constants and conversion functions for the Shift-JIS text
// memory writer.
// ----------------------------------------------------------------------------
package sjtw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int QUEUE_DEPTH = 4;

  // Item kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  // JIS codes that occupy a single cell.
  localparam logic [15:0] JIS_HALF_LO = 16'h2921;
  localparam logic [15:0] JIS_HALF_HI = 16'h2B7E;
  localparam logic [7:0]  ROW_BIAS    = 8'hE0;
  localparam logic [7:0]  RIGHT_HALF  = 8'h80;
  localparam logic [15:0] SPACE_WORD  = 16'h0020;

  typedef struct packed {
    logic       active;
    logic [6:0] column;
    logic [4:0] row;
    logic [7:0] attr_byte;
    logic       lead_pending;
    logic [7:0] lead_byte;
  } str_state_t;

  typedef struct packed {
    logic [10:0] cell_index;
    logic [15:0] char_word;
    logic [7:0]  attribute;
    logic        last;
  } cell_write_t;

  function automatic logic is_lead(input logic [7:0] b);
    return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
  endfunction

  // Attribute byte from the flag bits; the visible bit is always set.
  function automatic logic [7:0] attr_map(input logic [6:0] f);
    return {f[2], f[1], f[0], f[3], f[4], f[5], f[6], 1'b1};
  endfunction

  // Shift-JIS pair to JIS code; invalid pairs give zero.
  function automatic logic [15:0] sjis_to_jis(input logic [7:0] lead,
                                              input logic [7:0] trail);
    logic       lead_ok;
    logic       trail_ok;
    logic [7:0] hi;
    logic [7:0] lo;
    lead_ok  = (lead >= 8'h81 && lead <= 8'h9F) || (lead >= 8'hE0 && lead <= 8'hEF);
    trail_ok = (trail >= 8'h40 && trail <= 8'h7E) || (trail >= 8'h80 && trail <= 8'hFC);
    hi = (lead <= 8'h9F) ? (lead - 8'h71) : (lead - 8'hB1);
    hi = {hi[6:0], 1'b1};
    lo = (trail > 8'h7F) ? (trail - 8'h01) : trail;
    if (lo >= 8'h9E) begin
      lo = lo - 8'h7D;
      hi = hi + 8'h01;
    end else begin
      lo = lo - 8'h1F;
    end
    if (!lead_ok || !trail_ok) begin
      return 16'h0000;
    end
    return {hi, lo};
  endfunction

endpackage

// File: sv/sjtw_decode.sv
// ----------------------------------------------------------------------------
// sjtw_decode
// Combinational step: takes the registered item and the string state and
// gives the next state and up to two cell writes.
// ----------------------------------------------------------------------------
module sjtw_decode #(
  parameter int COLUMNS = sjtw_pkg::COLUMNS_DEF,
  parameter int ROWS    = sjtw_pkg::ROWS_DEF
) (
  input  sjtw_pkg::str_state_t  st,
  input  logic                  kind,
  input  logic [6:0]            start_column,
  input  logic [4:0]            start_row,
  input  logic [6:0]            attr_flags,
  input  logic [7:0]            byte_value,
  output sjtw_pkg::str_state_t  st_next,
  output logic [1:0]            wr_count,
  output sjtw_pkg::cell_write_t wr0,
  output sjtw_pkg::cell_write_t wr1
);

  logic [12:0] base;
  logic [15:0] jis;
  logic [7:0]  rb;
  logic [7:0]  cb;
  logic [1:0]  adv;
  logic [7:0]  col_sum;

  assign base = 13'(st.row) * 13'(COLUMNS);
  assign jis  = sjtw_pkg::sjis_to_jis(st.lead_byte, byte_value);
  assign rb   = jis[15:8] + sjtw_pkg::ROW_BIAS;
  assign cb   = jis[7:0];

  always_comb begin
    st_next  = st;
    wr_count = 2'd0;
    adv      = 2'd0;
    col_sum  = 8'd0;
    wr0.cell_index = 11'(base + 13'(st.column));
    wr0.char_word  = {8'h00, byte_value};
    wr0.attribute  = st.attr_byte;
    wr0.last       = 1'b1;
    wr1.cell_index = 11'(base + 13'(st.column) + 13'd1);
    wr1.char_word  = {cb, rb | sjtw_pkg::RIGHT_HALF};
    wr1.attribute  = st.attr_byte;
    wr1.last       = 1'b1;

    if (kind == sjtw_pkg::KIND_START) begin
      st_next.attr_byte    = sjtw_pkg::attr_map(attr_flags);
      st_next.column       = start_column;
      st_next.row          = start_row;
      st_next.lead_pending = 1'b0;
      st_next.lead_byte    = 8'h00;
      st_next.active       = ({1'b0, start_column} < 8'(COLUMNS)) &&
                             ({1'b0, start_row} < 6'(ROWS));
    end else if (st.active) begin
      if (st.lead_pending) begin
        st_next.lead_pending = 1'b0;
        if (byte_value == 8'h00) begin
          st_next.active = 1'b0;
        end else if (jis >= sjtw_pkg::JIS_HALF_LO && jis <= sjtw_pkg::JIS_HALF_HI) begin
          wr_count      = 2'd1;
          wr0.char_word = {cb, rb | sjtw_pkg::RIGHT_HALF};
          adv           = 2'd1;
        end else if (st.column == 7'(COLUMNS - 1)) begin
          wr_count      = 2'd1;
          wr0.char_word = sjtw_pkg::SPACE_WORD;
          adv           = 2'd1;
        end else begin
          wr_count      = 2'd2;
          wr0.char_word = {cb, rb};
          wr0.last      = 1'b0;
          adv           = 2'd2;
        end
      end else if (byte_value == 8'h00) begin
        st_next.active = 1'b0;
      end else if (sjtw_pkg::is_lead(byte_value)) begin
        st_next.lead_pending = 1'b1;
        st_next.lead_byte    = byte_value;
      end else begin
        wr_count = 2'd1;
        adv      = 2'd1;
      end

      if (adv != 2'd0) begin
        col_sum        = {1'b0, st.column} + {6'd0, adv};
        st_next.column = col_sum[6:0];
        if (col_sum >= 8'(COLUMNS)) begin
          st_next.active = 1'b0;
        end
      end
    end
  end

endmodule

// File: sv/sjtw_result_queue.sv
// ----------------------------------------------------------------------------
// sjtw_result_queue
// Shift queue of cell writes; entry zero drives the output port. Takes up to
// two writes per cycle and gives one per cycle when popped.
// ----------------------------------------------------------------------------
module sjtw_result_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_count,
  input  sjtw_pkg::cell_write_t push0,
  input  sjtw_pkg::cell_write_t push1,
  input  logic                  pop,
  output sjtw_pkg::cell_write_t head,
  output logic                  head_valid,
  output logic                  room2
);

  localparam int DEPTH = sjtw_pkg::QUEUE_DEPTH;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  sjtw_pkg::cell_write_t entries      [DEPTH];
  sjtw_pkg::cell_write_t entries_next [DEPTH];
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         kept;
  logic [IW-1:0]         wr_at;

  assign head       = entries[0];
  assign head_valid = (count != '0);
  assign room2      = (count <= CW'(DEPTH - 2));
  assign wr_at      = kept[IW-1:0];

  always_comb begin
    entries_next = entries;
    kept         = count;
    if (pop && head_valid) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        entries_next[i] = entries[i + 1];
      end
      kept = count - CW'(1);
    end
    if (push_count != 2'd0) begin
      entries_next[wr_at] = push0;
    end
    if (push_count == 2'd2) begin
      entries_next[wr_at + IW'(1)] = push1;
    end
    count_next = kept + CW'(push_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    entries <= entries_next;
  end

endmodule

// File: sv/shift_jis_text_ram_writer.sv
// ----------------------------------------------------------------------------
// shift_jis_text_ram_writer
// Turns a stream of start items and Shift-JIS bytes into text memory cell
// writes with JIS character words and a display attribute byte.
// ----------------------------------------------------------------------------
// Path: a byte is held in the input register, decoded once the result queue
//   has room for two writes, and its cell writes are then offered from the
//   result queue.
// Throughput: one item per cycle while the queue has room for two writes; a
//   full-width character gives two writes, paced by the single output port.
// Reset: synchronous rst closes any open string, drops a held lead byte,
//   empties the input register and the result queue.
// ----------------------------------------------------------------------------
module shift_jis_text_ram_writer #(
  parameter int COLUMNS = sjtw_pkg::COLUMNS_DEF,
  parameter int ROWS    = sjtw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        kind,
  input  logic [6:0]  start_column,
  input  logic [4:0]  start_row,
  input  logic [6:0]  attr_flags,
  input  logic [7:0]  byte_value,
  // Result channel.
  output logic        result_valid,
  input  logic        result_stall,
  output logic [10:0] cell_index,
  output logic [15:0] char_word,
  output logic [7:0]  attribute,
  output logic        last
);

  // Input register: one item waiting to be decoded.
  logic       pipe_valid;
  logic       pipe_kind;
  logic [6:0] pipe_column;
  logic [4:0] pipe_row;
  logic [6:0] pipe_flags;
  logic [7:0] pipe_byte;

  // String state, updated when the registered item is decoded.
  sjtw_pkg::str_state_t  st;
  sjtw_pkg::str_state_t  st_next;

  logic [1:0]            wr_count;
  sjtw_pkg::cell_write_t wr0;
  sjtw_pkg::cell_write_t wr1;
  sjtw_pkg::cell_write_t head;
  logic                  head_valid;
  logic                  room2;
  logic                  fire;
  logic                  take;

  // The registered item is decoded once the queue has room for the worst
  // case of two writes. The input register refills in the same cycle.
  assign fire       = pipe_valid && room2;
  assign item_stall = pipe_valid && !room2;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (take) begin
      pipe_valid <= 1'b1;
    end else if (fire) begin
      pipe_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pipe_kind   <= kind;
      pipe_column <= start_column;
      pipe_row    <= start_row;
      pipe_flags  <= attr_flags;
      pipe_byte   <= byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  sjtw_decode #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_decode (
    .st           (st),
    .kind         (pipe_kind),
    .start_column (pipe_column),
    .start_row    (pipe_row),
    .attr_flags   (pipe_flags),
    .byte_value   (pipe_byte),
    .st_next      (st_next),
    .wr_count     (wr_count),
    .wr0          (wr0),
    .wr1          (wr1)
  );

  // Writes enter the queue only when the item is actually decoded.
  sjtw_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (fire ? wr_count : 2'd0),
    .push0      (wr0),
    .push1      (wr1),
    .pop        (!result_stall),
    .head       (head),
    .head_valid (head_valid),
    .room2      (room2)
  );

  assign result_valid = head_valid;
  assign cell_index   = head.cell_index;
  assign char_word    = head.char_word;
  assign attribute    = head.attribute;
  assign last         = head.last;

endmodule

// File: sv/sjtw_checker.sv
// ----------------------------------------------------------------------------
// sjtw_checker
// Port-level checks for the Shift-JIS text memory writer, bound to the top.
// ----------------------------------------------------------------------------
module sjtw_checker #(
  parameter int COLUMNS = sjtw_pkg::COLUMNS_DEF,
  parameter int ROWS    = sjtw_pkg::ROWS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        kind,
  input logic [6:0]  start_column,
  input logic [4:0]  start_row,
  input logic [6:0]  attr_flags,
  input logic [7:0]  byte_value,
  input logic        result_valid,
  input logic        result_stall,
  input logic [10:0] cell_index,
  input logic [15:0] char_word,
  input logic [7:0]  attribute,
  input logic        last
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result withdrawn while stalled");

  // A stalled result does not change.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      $stable(cell_index) && $stable(char_word) && $stable(attribute) && $stable(last))
    else $error("result changed while stalled");

  // Reset leaves nothing to deliver.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered right after reset");

  // Every written attribute carries the visible bit.
  a_visible: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> attribute[0])
    else $error("attribute without visible bit");

  // Cell writes stay inside the text area.
  a_in_area: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (COLUMNS * ROWS > 2048) || (int'(cell_index) < COLUMNS * ROWS))
    else $error("cell index outside text area");

endmodule

bind shift_jis_text_ram_writer sjtw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_sjtw_checker (.*);
